### rtl/core/sib_pkg.sv
// sib_pkg: shared constants, codes and beat types for the sorted insert buffer
// used by sib_cell and sorted_insert_buffer_unit; depends on nothing
`timescale 1ns / 1ps

package sib_pkg;

   localparam int DEPTH     = 16;
   localparam int KEY_WIDTH = 8;

   // fixed field widths of the beats
   localparam int OPCODE_W  = 1;
   localparam int POS_W     = 4;
   localparam int STATUS_W  = 2;
   localparam int RANK_W    = 4;
   localparam int CNT_FLD_W = 5;
   localparam int RKEY_W    = 8;

   // internal count register holds 0..DEPTH
   localparam int COUNT_W   = $clog2(DEPTH + 1);

   localparam logic [OPCODE_W-1:0] OP_INSERT = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_READ   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   typedef logic [KEY_WIDTH-1:0] key_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [7:0]          key;
      logic [POS_W-1:0]    position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [RANK_W-1:0]    rank;
      logic [CNT_FLD_W-1:0] count;
      logic [RKEY_W-1:0]    read_key;
   } rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic    load;
      key_type new_key;
   } sib_bcast_type;

   // handed from a cell to its right neighbor
   typedef struct packed {
      logic    gt;
      key_type key;
   } sib_link_type;

endpackage

### rtl/core/sib_cell.sv
// sib_cell: one slot of the sorted chain, holds a key and shifts right on insert
// depends on sib_pkg
`timescale 1ns / 1ps

module sib_cell (
   input  logic                  clock,
   input  sib_pkg::sib_bcast_type bcast,
   input  logic                  occupied,
   input  sib_pkg::sib_link_type left,
   output sib_pkg::sib_link_type right,
   output logic                  ins_here
);
   import sib_pkg::*;

   key_type key_ff;
   key_type key_in;
   logic    gt;

   // new key goes past this slot only if strictly larger
   assign gt       = occupied && (bcast.new_key > key_ff);
   assign ins_here = left.gt && !gt;

   always_comb begin
      key_in = key_ff;
      if (bcast.load && !gt) begin
         key_in = left.gt ? bcast.new_key : left.key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign right.gt  = gt;
   assign right.key = key_ff;

endmodule

### rtl/core/sorted_insert_buffer_unit.sv
// sorted_insert_buffer_unit: top level, a chain of sib_cell slots plus count
// and output register; depends on sib_pkg and sib_cell
`timescale 1ns / 1ps

// Usage
// Keeps up to DEPTH keys in ascending order in a row of cells. Each request
// beat on req_* is either an insert (key placed ahead of equal keys) or a
// read of the key at a sorted position. Every request yields exactly one
// response beat on rsp_* with status, rank, count and read_key.
// An insert compares the key against all cells at once; in the same cycle
// the insertion slot takes the key and each slot past it loads from its
// left neighbor, so one request is taken per cycle while req_stall is low.
// Responses register on accept; a read selects a cell via a position mux.
// When the receiver raises rsp_stall the response holds and req_stall is
// raised only while that held response is still waiting, so the block
// keeps taking requests whenever the output register is free or drains.
// Reset clears the key count and the response valid; the key slots are
// not cleared, since only slots below the count are ever looked at.

module sorted_insert_buffer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sib_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sib_pkg::rsp_type rsp_payload
);
   import sib_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   sib_bcast_type      bcast;
   sib_link_type       link [DEPTH+1];
   logic [DEPTH-1:0]   ins_here;
   logic [DEPTH-1:0]   occupied;

   logic               accept;
   logic               is_insert;
   logic               full;
   logic [RANK_W-1:0]  rank_enc;
   key_type            read_sel;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_insert = (req_payload.opcode == OP_INSERT);
   assign full      = (count_ff >= COUNT_W'(DEPTH));

   assign bcast.load    = accept && is_insert && !full;
   assign bcast.new_key = KEY_WIDTH'(req_payload.key);

   // slot zero always sees a smaller neighbor
   assign link[0].gt  = 1'b1;
   assign link[0].key = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign occupied[i] = (int'(count_ff) > i);
      sib_cell u_cell (
         .clock    (clock),
         .bcast    (bcast),
         .occupied (occupied[i]),
         .left     (link[i]),
         .right    (link[i+1]),
         .ins_here (ins_here[i])
      );
   end

   // exactly one slot takes the key when not full
   always_comb begin
      rank_enc = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (ins_here[i]) begin
            rank_enc = rank_enc | RANK_W'(i);
         end
      end
   end

   always_comb begin
      read_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (int'(req_payload.position) == i) begin
            read_sel = link[i+1].key;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (bcast.load) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_comb begin
      rsp_in          = rsp_ff;
      rsp_in.status   = ST_OK;
      rsp_in.rank     = '0;
      rsp_in.count    = CNT_FLD_W'(count_ff);
      rsp_in.read_key = '0;
      if (is_insert) begin
         if (full) begin
            rsp_in.status = ST_FULL;
         end else begin
            rsp_in.rank  = rank_enc;
            rsp_in.count = CNT_FLD_W'(count_in);
         end
      end else if (COUNT_W'(req_payload.position) >= count_ff) begin
         rsp_in.status = ST_RANGE;
      end else begin
         rsp_in.read_key = RKEY_W'(read_sel);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
